// ===== rtl/mbdsa_pkg.sv =====
// shared constants and helpers for the mipmap box downsampler
`timescale 1ns / 1ps

package mbdsa_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;

  localparam int DIM_W  = 12;
  localparam int POS_W  = 11;
  localparam int SLOT_W = $clog2(LINE_DEPTH);

  localparam int PIX_W  = 8;
  localparam int PAIR_W = 9;
  localparam int QUAD_W = 10;
  localparam int PROD_W = 20;
  localparam int LINE_W = 4 * PAIR_W;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH  = 2'd0,
    CFG_SOURCE_HEIGHT = 2'd1
  } cfg_reg_t;

  // floor(x / 255) for x below 65280: underestimate then one correction step
  function automatic logic [PIX_W-1:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    logic [8:0]  q0;
    logic [16:0] prod;
    logic [16:0] rem;
    sum  = {1'b0, x} + {9'd0, x[15:8]};
    q0   = sum[16:8];
    prod = {q0, 8'd0} - {8'd0, q0};
    rem  = {1'b0, x} - prod;
    if (rem >= 17'd255) begin
      q0 = q0 + 9'd1;
    end
    return q0[PIX_W-1:0];
  endfunction

endpackage

// ===== rtl/mbdsa_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module mbdsa_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/mipmap_box_downsample_alpha_weighted.sv =====
// mipmap box downsampler with alpha-weighted colour averaging
// a transfer's result is registered in stage 1, stage 2 and the output register
// one source pixel per cycle unless stalled; pixels with no result leave bubbles
// the line buffer is one ram read and one ram write port; stalls back up per stage
// rst_n (synchronous, active low) sets both dimensions to 2 and the position to 0
`timescale 1ns / 1ps

module mipmap_box_downsample_alpha_weighted (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  // source pixels
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // red_in, green_in, blue_in, alpha_in
  // reduced pixels
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // red_out, green_out, blue_out, alpha_out
  output logic        out_tlast   // last_pixel
);

  localparam int PW = mbdsa_pkg::PIX_W;
  localparam int SW = mbdsa_pkg::PAIR_W;
  localparam int QW = mbdsa_pkg::QUAD_W;
  localparam int RW = mbdsa_pkg::PROD_W;

  // configuration
  logic [mbdsa_pkg::DIM_W-1:0] w_r, h_r;
  logic [mbdsa_pkg::DIM_W-1:0] cfg_clamped;
  logic                        cfg_fire, cfg_hit;

  // position
  logic [mbdsa_pkg::POS_W-1:0] col_r, row_r, col_nxt, row_nxt;
  logic [mbdsa_pkg::DIM_W-1:0] col_inc, row_inc;

  // decode
  logic                        in_fire;
  logic                        w_is1, h_is1, mode2d;
  logic [mbdsa_pkg::DIM_W-1:0] cend, rend, dim, dend;
  logic [mbdsa_pkg::DIM_W-1:0] col_x, row_x, pos;
  logic                        in_range, odd_step, emit, last;
  logic [31:0]                 held_r;
  logic [SW-1:0]               pair [4];
  logic [mbdsa_pkg::LINE_W-1:0] pair_packed, line_rd;
  logic                        line_we;

  // stages
  logic          en1, en2, en3;
  logic          v1_r, v2_r, v3_r;
  logic          m1_r, m2_r;
  logic          l1_r, l2_r, l3_r;
  logic [SW-1:0] s1_r [4];
  logic [QW-1:0] s2 [4];
  logic [RW-1:0] p2_r [3];
  logic [QW-1:0] a2_r;
  logic [RW-1:0] scaled [3];
  logic [PW-1:0] q3 [3];
  logic [PW-1:0] a3;
  logic [31:0]   o3_r;

  // configuration port
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_fire && ((cfg_index == mbdsa_pkg::CFG_SOURCE_WIDTH) ||
                                  (cfg_index == mbdsa_pkg::CFG_SOURCE_HEIGHT));

  always_comb begin
    cfg_clamped = cfg_data;
    if (cfg_data == '0) begin
      cfg_clamped = mbdsa_pkg::DIM_W'(1);
    end else if ((cfg_index == mbdsa_pkg::CFG_SOURCE_WIDTH) &&
                 (cfg_data > mbdsa_pkg::DIM_W'(mbdsa_pkg::MAX_WIDTH))) begin
      cfg_clamped = mbdsa_pkg::DIM_W'(mbdsa_pkg::MAX_WIDTH);
    end else if ((cfg_index == mbdsa_pkg::CFG_SOURCE_HEIGHT) &&
                 (cfg_data > mbdsa_pkg::DIM_W'(mbdsa_pkg::MAX_HEIGHT))) begin
      cfg_clamped = mbdsa_pkg::DIM_W'(mbdsa_pkg::MAX_HEIGHT);
    end
  end

  // stage enables, each stage moves when the one after it can take
  assign en3       = !v3_r || out_tready;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;
  assign in_fire   = in_tvalid && in_tready;

  // pixel position decode
  always_comb begin
    w_is1    = (w_r == mbdsa_pkg::DIM_W'(1));
    h_is1    = (h_r == mbdsa_pkg::DIM_W'(1));
    mode2d   = !w_is1 && !h_is1;
    cend     = {w_r[mbdsa_pkg::DIM_W-1:1], 1'b0};
    rend     = {h_r[mbdsa_pkg::DIM_W-1:1], 1'b0};
    dim      = w_is1 ? h_r : w_r;
    dend     = {dim[mbdsa_pkg::DIM_W-1:1], 1'b0};
    col_x    = {1'b0, col_r};
    row_x    = {1'b0, row_r};
    pos      = col_x + row_x;
    in_range = 1'b0;
    odd_step = 1'b0;
    last     = 1'b0;
    if (mode2d) begin
      in_range = (col_x < cend) && (row_x < rend);
      odd_step = col_r[0];
      last     = (col_x == cend - 1'b1) && (row_x == rend - 1'b1);
      emit     = in_range && col_r[0] && row_r[0];
    end else begin
      in_range = !(w_is1 && h_is1) && (pos < dend);
      odd_step = pos[0];
      last     = (pos == dend - 1'b1);
      emit     = in_range && pos[0];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pair[i] = SW'(held_r[i*PW +: PW]) + SW'(in_tdata[i*PW +: PW]);
    end
    pair_packed = {pair[3], pair[2], pair[1], pair[0]};
    line_we     = in_fire && mode2d && in_range && col_r[0] && !row_r[0];
  end

  // next position with wrap at the end of a row and of the frame
  always_comb begin
    col_inc = col_x + 1'b1;
    row_inc = row_x + 1'b1;
    col_nxt = col_inc[mbdsa_pkg::POS_W-1:0];
    row_nxt = row_r;
    if (col_inc == w_r) begin
      col_nxt = '0;
      row_nxt = (row_inc == h_r) ? '0 : row_inc[mbdsa_pkg::POS_W-1:0];
    end
  end

  mbdsa_ram #(
    .WIDTH (mbdsa_pkg::LINE_W),
    .DEPTH (mbdsa_pkg::LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (col_r[mbdsa_pkg::POS_W-1:1]),
    .wdata (pair_packed),
    .re    (in_fire),
    .raddr (col_r[mbdsa_pkg::POS_W-1:1]),
    .rdata (line_rd)
  );

  // stage 2: in 2d mode add the even row pair sums, then weight by alpha
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s2[i] = m1_r ? QW'(s1_r[i]) + QW'(line_rd[i*SW +: SW]) : QW'(s1_r[i]);
    end
  end

  // stage 3: divide colours by 255 times count squared, alpha by the count
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      scaled[i] = m2_r ? p2_r[i] : {p2_r[i][RW-3:0], 2'b00};
      q3[i]     = mbdsa_pkg::div255(scaled[i][RW-1:4]);
    end
    a3 = m2_r ? a2_r[QW-1:2] : a2_r[PW:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r   <= mbdsa_pkg::DIM_W'(2);
      h_r   <= mbdsa_pkg::DIM_W'(2);
      col_r <= '0;
      row_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      if (cfg_fire && (cfg_index == mbdsa_pkg::CFG_SOURCE_WIDTH)) begin
        w_r <= cfg_clamped;
      end
      if (cfg_fire && (cfg_index == mbdsa_pkg::CFG_SOURCE_HEIGHT)) begin
        h_r <= cfg_clamped;
      end
      if (cfg_hit) begin
        col_r <= '0;
        row_r <= '0;
      end else if (in_fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (en1) begin
        v1_r <= in_fire && emit;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire && in_range && !odd_step) begin
      held_r <= in_tdata;
    end
    if (en1) begin
      m1_r <= mode2d;
      l1_r <= last;
      for (int i = 0; i < 4; i++) begin
        s1_r[i] <= pair[i];
      end
    end
    if (en2) begin
      m2_r <= m1_r;
      l2_r <= l1_r;
      a2_r <= s2[3];
      for (int i = 0; i < 3; i++) begin
        p2_r[i] <= s2[i] * s2[3];
      end
    end
    if (en3) begin
      l3_r <= l2_r;
      o3_r <= {a3, q3[2], q3[1], q3[0]};
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = o3_r;
  assign out_tlast  = l3_r;

  // position never leaves the frame
  a_col_in_frame : assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, col_r} < w_r))
    else $error("column position outside frame");

  a_row_in_frame : assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, row_r} < h_r))
    else $error("row position outside frame");

  // a write to the width or height register restarts the frame
  a_cfg_restart : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (col_r == '0) && (row_r == '0))
    else $error("frame not restarted after register write");

  // a 1x1 source never starts a result
  a_no_result_1x1 : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && w_is1 && h_is1 && en1) |=> !v1_r)
    else $error("result started for 1x1 source");

  // a stalled first stage keeps its item
  a_stage1_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !en2) |=> v1_r && $stable(l1_r))
    else $error("first stage lost item while stalled");

endmodule
